[sv/contiguous_range_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Contiguous range allocator assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_RANGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_RANGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define CRA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define CRA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define CRA_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define CRA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[sv/cra_pkg.sv]
// ----------------------------------------------------------------------------
// Contiguous range allocator package
// Table size, derived widths, operation codes and channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package cra_pkg;

    localparam int ENTRIES = 1024;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RUN_W   = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;
    localparam int EXT_W   = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [10:0] run_length;
        logic [9:0]  entry_index;
    } t_req;

    typedef struct packed {
        logic       ok;
        logic [9:0] run_start;
        logic       entry_free;
    } t_rsp;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

endpackage

`default_nettype wire

[sv/cra_if.sv]
// ----------------------------------------------------------------------------
// Contiguous range allocator channels
// Valid/ready request and response channels with packed payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface cra_req_if;
    logic          valid;
    logic          ready;
    cra_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cra_rsp_if;
    logic          valid;
    logic          ready;
    cra_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/contiguous_range_allocator.sv]
// ----------------------------------------------------------------------------
// Contiguous range allocator
// First-fit allocation of runs of free entries in a one-bit occupancy table.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries operation, run_length and entry_index; o_rsp returns ok,
//   run_start and entry_free, one response per request, in order.
//   Allocate reads the occupancy memory one entry per cycle from entry 0,
//   then writes the found run one entry per cycle. Free clears an in-range
//   entry when the request is taken; query reads the entry then and answers
//   from the registered read. The one-read-per-cycle memory port sets the
//   allocate time; one request is in work at a time.
//   After reset the block clears the memory, one entry per cycle, with
//   i_req.ready low; then every entry is free.
//   The response sits in an output register; while o_rsp is stalled the
//   block still takes a new request and works on it, and holds its result
//   until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "contiguous_range_allocator_defines.svh"

module contiguous_range_allocator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cra_req_if.sink   i_req,
    cra_rsp_if.source o_rsp
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_QWAIT = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    localparam logic [cra_pkg::ADDR_W-1:0] LAST = cra_pkg::ADDR_W'(cra_pkg::ENTRIES - 1);

    logic [2:0]                   r_state, n_state;
    logic [cra_pkg::ADDR_W-1:0]   r_issue, n_issue;
    logic                         r_iss_more, n_iss_more;
    logic                         r_chk_vld, n_chk_vld;
    logic [cra_pkg::ADDR_W-1:0]   r_chk_idx, n_chk_idx;
    logic [cra_pkg::RUN_W-1:0]    r_run, n_run;
    logic [cra_pkg::RUN_W-1:0]    r_want, n_want;
    logic [cra_pkg::ADDR_W-1:0]   r_mark, n_mark;
    logic [cra_pkg::ADDR_W-1:0]   r_mark_end, n_mark_end;
    logic                         r_q_range, n_q_range;
    cra_pkg::t_rsp                r_res, n_res;
    cra_pkg::t_rsp                r_out;
    logic                         r_out_vld, n_out_vld;

    cra_pkg::t_mem_req            mem_req;
    logic                         rd_data;
    cra_pkg::t_req                req;
    logic [cra_pkg::EXT_W-1:0]    idx_ext;
    logic                         in_range;
    logic [cra_pkg::ADDR_W-1:0]   in_addr;
    logic [cra_pkg::RUN_W-1:0]    want_in;
    logic                         accept;
    logic [cra_pkg::RUN_W-1:0]    run_nx;
    logic [cra_pkg::RUN_W-1:0]    start_w;
    logic                         hit;
    logic                         load;

    cra_mem u_mem (
        .i_clk     (i_clk),
        .i_mem     (mem_req),
        .o_rd_data (rd_data)
    );

    assign req      = i_req.payload;
    assign idx_ext  = cra_pkg::EXT_W'(req.entry_index);
    assign in_range = idx_ext < cra_pkg::EXT_W'(cra_pkg::ENTRIES);
    assign in_addr  = cra_pkg::ADDR_W'(idx_ext);
    assign want_in  = (req.run_length == '0) ? cra_pkg::RUN_W'(1)
                                             : cra_pkg::RUN_W'(req.run_length);
    assign accept   = i_req.valid && i_req.ready;
    assign run_nx   = r_run + cra_pkg::RUN_W'(1);
    assign start_w  = cra_pkg::RUN_W'(r_chk_idx) + cra_pkg::RUN_W'(1) - run_nx;
    assign hit      = r_chk_vld && !rd_data && (run_nx >= r_want);
    assign load     = (r_state == ST_RESP) && (!r_out_vld || o_rsp.ready);

    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

    always_comb begin
        n_state    = r_state;
        n_issue    = r_issue;
        n_iss_more = r_iss_more;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_run      = r_run;
        n_want     = r_want;
        n_mark     = r_mark;
        n_mark_end = r_mark_end;
        n_q_range  = r_q_range;
        n_res      = r_res;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_mark;
        mem_req.wr_data = 1'b1;
        mem_req.rd_addr = r_issue;
        case (r_state)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_issue;
                mem_req.wr_data = 1'b0;
                n_issue         = r_issue + cra_pkg::ADDR_W'(1);
                if (r_issue == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mem_req.rd_addr = in_addr;
                if (accept) begin
                    case (req.operation)
                        cra_pkg::OP_ALLOC: begin
                            n_want     = want_in;
                            n_run      = '0;
                            n_issue    = '0;
                            n_iss_more = 1'b1;
                            n_chk_vld  = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        cra_pkg::OP_FREE: begin
                            mem_req.wr_en   = in_range;
                            mem_req.wr_addr = in_addr;
                            mem_req.wr_data = 1'b0;
                            n_res.ok         = 1'b1;
                            n_res.run_start  = '0;
                            n_res.entry_free = 1'b0;
                            n_state          = ST_RESP;
                        end
                        cra_pkg::OP_QUERY: begin
                            n_q_range = in_range;
                            n_state   = ST_QWAIT;
                        end
                        default: begin
                            n_res   = '0;
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_chk_vld = r_iss_more;
                n_chk_idx = r_issue;
                if (r_iss_more) begin
                    n_issue = r_issue + cra_pkg::ADDR_W'(1);
                    if (r_issue == LAST) begin
                        n_iss_more = 1'b0;
                    end
                end
                if (r_chk_vld) begin
                    if (rd_data) begin
                        n_run = '0;
                    end else if (hit) begin
                        n_mark           = cra_pkg::ADDR_W'(start_w);
                        n_mark_end       = r_chk_idx;
                        n_res.ok         = 1'b1;
                        n_res.run_start  = 10'(start_w);
                        n_res.entry_free = 1'b0;
                        n_state          = ST_MARK;
                    end else begin
                        n_run = run_nx;
                    end
                    if (!hit && (r_chk_idx == LAST)) begin
                        n_res   = '0;
                        n_state = ST_RESP;
                    end
                end
            end
            ST_MARK: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_mark;
                mem_req.wr_data = 1'b1;
                n_mark          = r_mark + cra_pkg::ADDR_W'(1);
                if (r_mark == r_mark_end) begin
                    n_state = ST_RESP;
                end
            end
            ST_QWAIT: begin
                n_res.ok         = 1'b1;
                n_res.run_start  = '0;
                n_res.entry_free = r_q_range && !rd_data;
                n_state          = ST_RESP;
            end
            ST_RESP: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld && !o_rsp.ready;
        if (load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_issue    <= '0;
            r_iss_more <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_run      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_iss_more <= n_iss_more;
            r_chk_vld  <= n_chk_vld;
            r_run      <= n_run;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_want     <= n_want;
        r_mark     <= n_mark;
        r_mark_end <= n_mark_end;
        r_q_range  <= n_q_range;
        r_res      <= n_res;
        if (load) begin
            r_out <= r_res;
        end
    end

    `CRA_ASSERT_IMPL(a_run_below_want, i_clk, i_rst_n, r_state == ST_SCAN, r_run < r_want)
    `CRA_ASSERT_IMPL(a_mark_in_run, i_clk, i_rst_n, r_state == ST_MARK, r_mark <= r_mark_end)
    `CRA_ASSERT_IMPL(a_write_states, i_clk, i_rst_n, mem_req.wr_en, (r_state == ST_CLEAR) || (r_state == ST_MARK) || (r_state == ST_IDLE))
    `CRA_ASSERT_NEXT(a_mark_sets_busy, i_clk, i_rst_n, (r_state == ST_MARK) && (r_mark == r_mark_end), r_state == ST_RESP)

endmodule

`default_nettype wire

[sv/cra_mem.sv]
// ----------------------------------------------------------------------------
// Occupancy memory
// One bit per entry, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cra_mem (
    input  wire logic              i_clk,
    input  wire cra_pkg::t_mem_req i_mem,
    output logic                   o_rd_data
);

    logic r_mem [cra_pkg::ENTRIES];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
        r_rd_data <= r_mem[i_mem.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Contiguous range allocator testbench
// Drives allocate, free, query and unused-code requests through the request
// channel with random gaps and response stalls. It keeps its own occupancy
// map to predict responses, takes the responses of typed directed rows from
// the table and compares each response transfer with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic TYPED = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam int RANDOM_ITEMS = 267;
    localparam int QUIET_ITEMS = 40;
    localparam int HOLD_CYCLES = 3000;
    localparam int HOLD_AFTER = 60;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 2 * cra_pkg::ENTRIES + 8;
    localparam longint WATCHDOG_DELAY = 64'd80_000_000;

    typedef struct packed {
        cra_pkg::t_req req;
        logic          typed;
        cra_pkg::t_rsp want;
    } t_row;

    localparam t_row DIRECTED_ROWS [0:22] = '{
        {cra_pkg::OP_QUERY, 11'd0,    10'd0,    TYPED,     1'b1, 10'd0, 1'b1},
        {cra_pkg::OP_QUERY, 11'd0,    10'd1023, TYPED,     1'b1, 10'd0, 1'b1},
        {cra_pkg::OP_ALLOC, 11'd2047, 10'd1023, TYPED,     1'b0, 10'd0, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd1025, 10'd0,    TYPED,     1'b0, 10'd0, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd0,    10'd0,    TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd1,    10'd0,    TYPED,     1'b1, 10'd1, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd3,    10'd0,    TYPED,     1'b1, 10'd2, 1'b0},
        {cra_pkg::OP_QUERY, 11'd0,    10'd4,    TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_QUERY, 11'd0,    10'd5,    TYPED,     1'b1, 10'd0, 1'b1},
        {cra_pkg::OP_ALLOC, 11'd1024, 10'd0,    TYPED,     1'b0, 10'd0, 1'b0},
        {cra_pkg::OP_FREE,  11'd0,    10'd1,    TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_FREE,  11'd0,    10'd1,    TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd2,    10'd0,    PREDICTED, 1'b0, 10'd0, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd1,    10'd0,    TYPED,     1'b1, 10'd1, 1'b0},
        {OP_UNUSED,         11'd2047, 10'd1023, TYPED,     1'b0, 10'd0, 1'b0},
        {cra_pkg::OP_QUERY, 11'd0,    10'd1,    PREDICTED, 1'b0, 10'd0, 1'b0},
        {cra_pkg::OP_FREE,  11'd0,    10'd3,    TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd2,    10'd0,    PREDICTED, 1'b0, 10'd0, 1'b0},
        {cra_pkg::OP_QUERY, 11'd0,    10'd1023, TYPED,     1'b1, 10'd0, 1'b1},
        {cra_pkg::OP_FREE,  11'd0,    10'd1023, TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_FREE,  11'd0,    10'd0,    TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_ALLOC, 11'd1,    10'd0,    TYPED,     1'b1, 10'd0, 1'b0},
        {cra_pkg::OP_QUERY, 11'd0,    10'd0,    TYPED,     1'b1, 10'd0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cra_req_if req_ch ();
    cra_rsp_if rsp_ch ();

    contiguous_range_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bit [cra_pkg::ENTRIES-1:0] taken_map = '0;
    int unsigned last_start = 0;
    int unsigned last_len = 1;
    cra_pkg::t_rsp pending_rsp [$];
    int mismatch_count = 0;
    int rsp_count = 0;
    bit quiet_tail = 1'b0;

    always #10 i_clk = ~i_clk;

    function automatic cra_pkg::t_rsp occupancy_step(input cra_pkg::t_req r);
        cra_pkg::t_rsp res;
        int unsigned want;
        int unsigned run;
        int unsigned i;
        int unsigned j;
        res = '0;
        if (r.operation == cra_pkg::OP_ALLOC) begin
            want = (r.run_length == 0) ? 1 : r.run_length;
            run = 0;
            i = 0;
            while (i < cra_pkg::ENTRIES && run < want) begin
                run = taken_map[i] ? 0 : run + 1;
                i++;
            end
            if (run >= want) begin
                for (j = i - want; j < i; j++) taken_map[j] = 1'b1;
                res.ok = 1'b1;
                res.run_start = 10'(i - want);
                last_start = i - want;
                last_len = want;
            end
        end else if (r.operation == cra_pkg::OP_FREE) begin
            if (r.entry_index < cra_pkg::ENTRIES) taken_map[r.entry_index] = 1'b0;
            res.ok = 1'b1;
        end else if (r.operation == cra_pkg::OP_QUERY) begin
            res.ok = 1'b1;
            res.entry_free = (r.entry_index < cra_pkg::ENTRIES)
                             && !taken_map[r.entry_index];
        end
        return res;
    endfunction

    task automatic pause_sender();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic offer(input cra_pkg::t_req r, input logic typed,
                         input cra_pkg::t_rsp typed_rsp);
        cra_pkg::t_rsp predicted;
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predicted = occupancy_step(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_rsp
        cra_pkg::t_rsp want;
        cra_pkg::t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            rsp_count++;
            if (pending_rsp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected response %0d: ok %0b run_start %0d entry_free %0b",
                             rsp_count, got.ok, got.run_start, got.entry_free);
            end else begin
                want = pending_rsp.pop_front();
                if (got.ok !== want.ok || got.run_start !== want.run_start
                        || got.entry_free !== want.entry_free) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch at response %0d: ok %0b/%0b run_start %0d/%0d %s %0b/%0b",
                                 rsp_count, want.ok, got.ok, want.run_start, got.run_start,
                                 "entry_free", want.entry_free, got.entry_free);
                end
            end
        end
    end

    initial begin : drive_ready
        bit held_once;
        held_once = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && !held_once && rsp_count >= HOLD_AFTER) begin
                held_once = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 9) < 2) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(WATCHDOG_DELAY);
        $display("FAIL");
        $finish;
    end

    initial begin : drive_requests
        cra_pkg::t_req r;
        int n;
        int k;
        int pick;
        int sel;
        int unsigned probe;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < $size(DIRECTED_ROWS); n++) begin
            pause_sender();
            offer(DIRECTED_ROWS[n].req, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            pick = $urandom_range(0, 99);
            r.run_length = 11'($urandom);
            r.entry_index = 10'($urandom);
            if (pick < 40) begin
                r.operation = cra_pkg::OP_ALLOC;
                sel = $urandom_range(0, 99);
                if (sel < 75)
                    r.run_length = 11'($urandom_range(1, 8));
                else if (sel < 92)
                    r.run_length = 11'($urandom_range(9, 48));
                else if (sel < 97)
                    r.run_length = 11'($urandom_range(49, 512));
                else if (sel < 98)
                    r.run_length = 11'd0;
                else
                    r.run_length = 11'($urandom_range(1024, 2047));
            end else if (pick < 72) begin
                r.operation = cra_pkg::OP_FREE;
                if ($urandom_range(0, 4) != 0) begin
                    probe = $urandom_range(0, 1) ? last_start
                                                 : $urandom_range(0, cra_pkg::ENTRIES - 1);
                    for (k = 0; k < cra_pkg::ENTRIES && !taken_map[probe]; k++)
                        probe = (probe + 1) % cra_pkg::ENTRIES;
                    r.entry_index = 10'(probe);
                end
            end else if (pick < 97) begin
                r.operation = cra_pkg::OP_QUERY;
                if ($urandom_range(0, 1))
                    r.entry_index = 10'(last_start + $urandom_range(0, last_len));
            end else begin
                r.operation = OP_UNUSED;
            end
            pause_sender();
            offer(r, PREDICTED, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
